// ===== src/hpbs_pkg.sv =====
`default_nettype none

package hpbs_pkg;

   localparam int CounterWidth = 16;
   localparam int PhaseWidth   = 7;
   localparam int CsrIndexWidth = 3;
   localparam int PulseEvery   = 100;

   typedef logic [CounterWidth-1:0] count_type;
   typedef logic [PhaseWidth-1:0]   phase_type;

   typedef enum logic [1:0] {
      MODE_ON       = 2'd0,
      MODE_SHUTTING = 2'd1,
      MODE_OFF      = 2'd2,
      MODE_RISING   = 2'd3
   } mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SHORT_MIN  = 3'd0,
      CSR_SHORT_MAX  = 3'd1,
      CSR_FORCE_OFF  = 3'd2,
      CSR_SEQ_TMO    = 3'd3,
      CSR_LOCKOUT    = 3'd4
   } csr_index_type;

   localparam count_type ShortMinReset  = 16'd1000;
   localparam count_type ShortMaxReset  = 16'd5000;
   localparam count_type ForceOffReset  = 16'd6000;
   localparam count_type SeqTmoReset    = 16'd15000;
   localparam count_type LockoutReset   = 16'd5000;

   typedef struct packed {
      count_type press_short_min;
      count_type press_short_max;
      count_type press_force_off;
      count_type sequence_timeout;
      count_type lockout_period;
   } cfg_type;

   // Sequence counter together with its value modulo the pulse spacing.
   typedef struct packed {
      count_type count;
      phase_type phase;
   } seq_type;

   typedef struct packed {
      count_type press_ticks;
      mode_type  mode;
      seq_type   seq;
      logic      lockout_flag;
      count_type lockout_ticks;
      logic      switch_line;
      logic      pc_rail;
      logic      sensor_rail;
   } state_type;

   typedef struct packed {
      logic button_pressed;
      logic host_5v_present;
   } req_type;

   typedef struct packed {
      logic     pc_switch_out;
      logic     pc_power_enable;
      logic     sensor_power_enable;
      mode_type mode_out;
      logic     lockout_out;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/hpbs_csr.sv =====
`default_nettype none

module hpbs_csr import hpbs_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire count_type                csr_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHORT_MIN: cfg_in.press_short_min  = csr_data;
            CSR_SHORT_MAX: cfg_in.press_short_max  = csr_data;
            CSR_FORCE_OFF: cfg_in.press_force_off  = csr_data;
            CSR_SEQ_TMO:   cfg_in.sequence_timeout = csr_data;
            CSR_LOCKOUT:   cfg_in.lockout_period   = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_short_min  <= ShortMinReset;
         cfg_ff.press_short_max  <= ShortMaxReset;
         cfg_ff.press_force_off  <= ForceOffReset;
         cfg_ff.sequence_timeout <= SeqTmoReset;
         cfg_ff.lockout_period   <= LockoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/hpbs_step.sv =====
`default_nettype none

module hpbs_step import hpbs_pkg::*; (
   input  cfg_type   cfg,
   input  state_type cur,
   input  req_type   req,
   output state_type nxt,
   output rsp_type   rsp
);

   localparam phase_type PhaseLast = phase_type'(PulseEvery - 1);
   localparam count_type CountMax  = '1;

   // One step of the sequence counter; the phase follows the count modulo
   // the pulse spacing, and restarts with it when the count wraps.
   function automatic seq_type seq_advance(input seq_type s);
      seq_type r;
      if (s.count == CountMax) begin
         r.count = '0;
         r.phase = '0;
      end else begin
         r.count = s.count + count_type'(1);
         r.phase = (s.phase == PhaseLast) ? '0 : s.phase + phase_type'(1);
      end
      return r;
   endfunction

   state_type st;

   always_comb begin
      st = cur;

      if (req.button_pressed && !st.lockout_flag) begin
         st.press_ticks = st.press_ticks + count_type'(1);
         if (st.press_ticks > cfg.press_short_min && st.press_ticks < cfg.press_short_max) begin
            if (st.mode == MODE_ON) begin
               st.mode = MODE_SHUTTING;
               st.seq  = '0;
            end else if (st.mode == MODE_OFF) begin
               st.mode = MODE_RISING;
               st.seq  = '0;
            end
         end else if (st.press_ticks > cfg.press_short_max) begin
            st.seq = seq_advance(st.seq);
            if (st.seq.phase == '0) begin
               st.switch_line = 1'b0;
            end
            if (st.press_ticks > cfg.press_force_off) begin
               st.lockout_flag = 1'b1;
               st.mode         = MODE_OFF;
               st.pc_rail      = 1'b0;
               st.press_ticks  = '0;
               st.seq          = '0;
            end
         end
      end else begin
         st.press_ticks = '0;
      end

      if (st.mode == MODE_SHUTTING) begin
         st.seq = seq_advance(st.seq);
         if (st.seq.phase == '0) begin
            st.switch_line = 1'b0;
         end
         if (st.seq.count > cfg.sequence_timeout) begin
            st.switch_line = 1'b1;
            st.seq         = '0;
            st.mode        = MODE_ON;
         end
         if (!req.host_5v_present) begin
            st.lockout_flag = 1'b1;
            st.seq          = '0;
            st.mode         = MODE_OFF;
            st.pc_rail      = 1'b0;
            st.sensor_rail  = 1'b0;
         end
      end else if (st.mode == MODE_RISING) begin
         st.seq         = seq_advance(st.seq);
         st.pc_rail     = 1'b1;
         st.sensor_rail = 1'b1;
         if (st.seq.count > cfg.sequence_timeout) begin
            st.switch_line = 1'b0;
            st.seq         = '0;
            st.mode        = MODE_OFF;
         end
         if (req.host_5v_present) begin
            st.lockout_flag = 1'b1;
            st.mode         = MODE_ON;
            st.seq          = '0;
            st.switch_line  = 1'b1;
         end
      end

      if (st.lockout_flag) begin
         st.lockout_ticks = st.lockout_ticks + count_type'(1);
      end
      if (st.lockout_ticks > cfg.lockout_period) begin
         st.lockout_flag  = 1'b0;
         st.lockout_ticks = '0;
      end
   end

   assign nxt = st;

   assign rsp.pc_switch_out       = st.switch_line;
   assign rsp.pc_power_enable     = st.pc_rail;
   assign rsp.sensor_power_enable = st.sensor_rail;
   assign rsp.mode_out            = st.mode;
   assign rsp.lockout_out         = st.lockout_flag;

endmodule

`default_nettype wire

// ===== src/host_power_button_sequencer_unit.sv =====
// Host power button sequencer.
// Each request is one 1 ms tick sample of the power button and the host 5 V
// sense line; each response carries the switch line, both rail enables, the
// mode and the lockout flag as they stand after that tick.
// A request is taken when req_valid is high and req_stall is low; a response
// is taken when rsp_valid is high and rsp_stall is low. Exactly one response
// follows every request, in order.
// The request lands in an input register, the tick update is combinational
// from that register and the state registers, and the response is held in
// an output register. One request per cycle is sustained while rsp_stall
// is low, since the tick update completes in the cycle it starts.
// When the receiver stalls, the output register holds its response and the
// input register keeps one more request; only then is req_stall raised.
// Registers are written through the csr_ port, which is always ready; write
// them only while no request is in flight.
// Synchronous reset empties both registers stages, loads the register reset
// values and puts the host on, both rails on, switch line released.
`default_nettype none

module host_power_button_sequencer_unit import hpbs_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  req_type                       req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire count_type                csr_data
);

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;

   logic      out_free;
   logic      advance;
   logic      take;

   // The port never pushes back on writes.
   assign csr_ready = 1'b1;

   hpbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hpbs_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (in_data_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // The output register is free when empty or being emptied this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // The held request is processed exactly when its response can be stored.
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.press_ticks   <= '0;
         state_ff.mode          <= MODE_ON;
         state_ff.seq           <= '0;
         state_ff.lockout_flag  <= 1'b0;
         state_ff.lockout_ticks <= '0;
         state_ff.switch_line   <= 1'b1;
         state_ff.pc_rail       <= 1'b1;
         state_ff.sensor_rail   <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
